### hw/rtl/lmps_pkg.sv
`timescale 1ns / 1ps

package lmps_pkg;

    // frame store geometry: row * 32 + column
    localparam int SIDE_W       = 5;
    localparam int STORE_SIDE   = 32;
    localparam int STORE_ADDR_W = 2 * SIDE_W;
    localparam int STORE_DEPTH  = 1 << STORE_ADDR_W;
    localparam int LEVEL_W      = 8;
    localparam int BYTE_W       = 8;

    // running column index, covers 8 sections of 8 columns plus one
    localparam int COL_W = 7;

    // display size after capping, holds 0..32
    localparam int DIM_W = 6;

    // configuration register widths
    localparam int SIZE_W  = 4;
    localparam int COUNT_W = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    // defaults for the top level parameters
    localparam int DEF_MAX_SECTIONS_WIDE = 4;
    localparam int DEF_MAX_SECTIONS_HIGH = 4;
    localparam int DEF_SECTION_BITS      = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTIONS_WIDE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTIONS_HIGH  = 2'd3;

    // configuration reset values
    localparam logic [SIZE_W-1:0]  RST_SECTION_WIDTH  = 4'd8;
    localparam logic [SIZE_W-1:0]  RST_SECTION_HEIGHT = 4'd8;
    localparam logic [COUNT_W-1:0] RST_SECTIONS_WIDE  = 3'd1;
    localparam logic [COUNT_W-1:0] RST_SECTIONS_HIGH  = 3'd1;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // byte kinds
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    // frame store write port
    typedef struct packed {
        logic                    en;
        logic [STORE_ADDR_W-1:0] addr;
        logic [LEVEL_W-1:0]      data;
    } fs_wr_t;

endpackage

### hw/rtl/led_matrix_pwm_row_scanner.sv
`timescale 1ns / 1ps

// Multiplexed LED matrix driver with an 8-bit software PWM. A 1024 x 8 frame
// store (row * 32 + column) holds one brightness per pixel. A pixel write
// (req_type 0) is ignored when the pixel lies outside the display; a clear
// (req_type 1) sweeps the store one entry per cycle and keeps in_stall high
// until the sweep ends; the same clearing pass runs after reset before the
// first word is accepted. A row tick (req_type 2) sends one active-low column
// byte per horizontal section, then one row-select byte per vertical section,
// one-hot in the section holding the scan row and zero elsewhere, with last
// set on the final byte. Column bytes come from a single comparator that
// walks the pixels of the row one per cycle through the registered read port
// of the frame store; out_stall holds the tick while a byte waits. Unknown
// requests are dropped. Configuration writes land at once and should only be
// issued while no row tick is in progress. A register value of zero counts as
// one and sizes above the parameter limits are clamped; the display is capped
// at 32 x 32 pixels.

module led_matrix_pwm_row_scanner
#(
    parameter int MAX_SECTIONS_WIDE = lmps_pkg::DEF_MAX_SECTIONS_WIDE,
    parameter int MAX_SECTIONS_HIGH = lmps_pkg::DEF_MAX_SECTIONS_HIGH,
    parameter int SECTION_BITS      = lmps_pkg::DEF_SECTION_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_we,
    input  logic [lmps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmps_pkg::CFG_W-1:0]        cfg_data,

    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [lmps_pkg::SIDE_W-1:0]       pixel_row,
    input  logic [lmps_pkg::SIDE_W-1:0]       pixel_col,
    input  logic [lmps_pkg::LEVEL_W-1:0]      pixel_level,

    // byte channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmps_pkg::BYTE_W-1:0]       out_byte,
    output logic                              byte_kind,
    output logic                              last
);

    localparam int NW_W = (MAX_SECTIONS_WIDE > 1) ? $clog2(MAX_SECTIONS_WIDE) : 1;
    localparam int NH_W = (MAX_SECTIONS_HIGH > 1) ? $clog2(MAX_SECTIONS_HIGH) : 1;

    localparam int SW = lmps_pkg::SIZE_W;
    localparam int DW = lmps_pkg::DIM_W;
    localparam int AW = lmps_pkg::STORE_ADDR_W;
    localparam int BW = lmps_pkg::BYTE_W;
    localparam int LW = lmps_pkg::LEVEL_W;
    localparam int RW = lmps_pkg::SIDE_W;
    localparam int CW = lmps_pkg::COL_W;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CLR  = 6'b000010,
        S_RD   = 6'b000100,
        S_CMP  = 6'b001000,
        S_EMIT = 6'b010000,
        S_ROW  = 6'b100000
    } state_t;

    // configuration registers
    logic [SW-1:0]                  section_width_reg;
    logic [SW-1:0]                  section_height_reg;
    logic [lmps_pkg::COUNT_W-1:0]   sections_wide_reg;
    logic [lmps_pkg::COUNT_W-1:0]   sections_high_reg;

    // sequencer and scan state
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [RW-1:0]   rrem_reg, rrem_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [2:0]      cidx_reg, cidx_next;
    logic [NW_W-1:0] sec_reg, sec_next;
    logic [NH_W-1:0] rsec_reg, rsec_next;
    logic [BW-1:0]   acc_reg, acc_next;
    logic [RW-1:0]   scan_row_reg, scan_row_next;
    logic [LW-1:0]   pwm_time_reg, pwm_time_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [BW-1:0]   out_byte_reg, out_byte_next;
    logic            byte_kind_reg, byte_kind_next;
    logic            last_reg, last_next;

    // effective geometry
    logic [SW-1:0]   sw_eff;
    logic [SW-1:0]   sh_eff;
    logic [SW-1:0]   nw_c;
    logic [SW-1:0]   nh_c;
    logic [2*SW-1:0] width_raw;
    logic [2*SW-1:0] height_raw;
    logic [DW-1:0]   width_eff;
    logic [DW-1:0]   height_eff;

    // datapath
    lmps_pkg::fs_wr_t fs_wr;
    logic [AW-1:0]   rd_addr;
    logic [LW-1:0]   rd_data;
    logic [CW-1:0]   rd_col;
    logic [LW-1:0]   level;
    logic [SW-1:0]   col_pos;
    logic [SW-1:0]   row_pos;
    logic            row_hit;
    logic            last_col;
    logic            last_sec;
    logic            last_rsec;
    logic            out_free;
    logic            in_take;
    logic [DW-1:0]   row_inc;

    // clamp a register: zero counts as one, above the limit counts as the limit
    function automatic logic [SW-1:0] clamp_reg(input logic [SW-1:0] v,
                                                  input logic [SW-1:0] hi);
        logic [SW-1:0] r;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign sw_eff = clamp_reg(section_width_reg, SW'(SECTION_BITS));
    assign sh_eff = clamp_reg(section_height_reg, SW'(SECTION_BITS));
    assign nw_c   = clamp_reg({1'b0, sections_wide_reg}, SW'(MAX_SECTIONS_WIDE));
    assign nh_c   = clamp_reg({1'b0, sections_high_reg}, SW'(MAX_SECTIONS_HIGH));

    assign width_raw  = {{SW{1'b0}}, sw_eff} * {{SW{1'b0}}, nw_c};
    assign height_raw = {{SW{1'b0}}, sh_eff} * {{SW{1'b0}}, nh_c};

    // display never exceeds the 32 x 32 store
    assign width_eff  = (width_raw > (2*SW)'(lmps_pkg::STORE_SIDE))
                        ? DW'(lmps_pkg::STORE_SIDE) : width_raw[DW-1:0];
    assign height_eff = (height_raw > (2*SW)'(lmps_pkg::STORE_SIDE))
                        ? DW'(lmps_pkg::STORE_SIDE) : height_raw[DW-1:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_width_reg  <= lmps_pkg::RST_SECTION_WIDTH;
            section_height_reg <= lmps_pkg::RST_SECTION_HEIGHT;
            sections_wide_reg  <= lmps_pkg::RST_SECTIONS_WIDE;
            sections_high_reg  <= lmps_pkg::RST_SECTIONS_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmps_pkg::REG_SECTION_WIDTH:  section_width_reg  <= cfg_data;
                lmps_pkg::REG_SECTION_HEIGHT: section_height_reg <= cfg_data;
                lmps_pkg::REG_SECTIONS_WIDE:
                    sections_wide_reg <= cfg_data[lmps_pkg::COUNT_W-1:0];
                lmps_pkg::REG_SECTIONS_HIGH:
                    sections_high_reg <= cfg_data[lmps_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // frame store, one pixel read per cycle
    lmps_frame_store u_store
    (
        .clk     (clk),
        .wr      (fs_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // while comparing, fetch one column ahead so a pixel lands every cycle
    assign rd_col  = (state_reg == S_CMP) ? (col_reg + CW'(1)) : col_reg;
    assign rd_addr = {row_reg, rd_col[RW-1:0]};

    // pixels past the store read as dark
    assign level   = (col_reg < CW'(lmps_pkg::STORE_SIDE)) ? rd_data : '0;
    // bit sw_eff - 1 of a column byte is the leftmost column of the section
    assign col_pos = sw_eff - SW'(1) - {1'b0, cidx_reg};
    assign last_col = ({1'b0, cidx_reg} == (sw_eff - SW'(1)));
    assign last_sec = (sec_reg == NW_W'(nw_c - SW'(1)));
    assign last_rsec = (rsec_reg == NH_W'(nh_c - SW'(1)));

    // row select: walk sections subtracting the section height until it fits
    assign row_hit = !found_reg && (rrem_reg < {1'b0, sh_eff});
    assign row_pos = sh_eff - SW'(1) - rrem_reg[SW-1:0];
    assign row_inc = {1'b0, row_reg} + DW'(1);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        row_next       = row_reg;
        rrem_next      = rrem_reg;
        found_next     = found_reg;
        col_next       = col_reg;
        cidx_next      = cidx_reg;
        sec_next       = sec_reg;
        rsec_next      = rsec_reg;
        acc_next       = acc_reg;
        scan_row_next  = scan_row_reg;
        pwm_time_next  = pwm_time_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        byte_kind_next = byte_kind_reg;
        last_next      = last_reg;
        fs_wr.en       = 1'b0;
        fs_wr.addr     = {pixel_row, pixel_col};
        fs_wr.data     = pixel_level;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (req_type)
                        lmps_pkg::REQ_WRITE:
                        begin
                            fs_wr.en = ({1'b0, pixel_row} < height_eff)
                                       && ({1'b0, pixel_col} < width_eff);
                        end
                        lmps_pkg::REQ_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLR;
                        end
                        lmps_pkg::REQ_TICK:
                        begin
                            // a stale row after a resize scans row 0
                            row_next   = ({1'b0, scan_row_reg} >= height_eff)
                                         ? '0 : scan_row_reg;
                            col_next   = '0;
                            cidx_next  = '0;
                            sec_next   = '0;
                            acc_next   = '1;
                            state_next = S_RD;
                        end
                        default: ;
                    endcase
                end
            end

            S_CLR:
            begin
                fs_wr.en   = 1'b1;
                fs_wr.addr = clr_addr_reg;
                fs_wr.data = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (level > pwm_time_reg)
                begin
                    acc_next = acc_reg & ~(BW'(1) << col_pos[2:0]);
                end
                col_next  = col_reg + CW'(1);
                cidx_next = cidx_reg + 3'd1;
                if (last_col)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = acc_reg;
                    byte_kind_next = lmps_pkg::KIND_COLUMN;
                    last_next      = 1'b0;
                    cidx_next      = '0;
                    acc_next       = '1;
                    if (last_sec)
                    begin
                        rsec_next  = '0;
                        rrem_next  = row_reg;
                        found_next = 1'b0;
                        state_next = S_ROW;
                    end
                    else
                    begin
                        sec_next   = sec_reg + NW_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_ROW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = row_hit ? (BW'(1) << row_pos[2:0]) : '0;
                    byte_kind_next = lmps_pkg::KIND_ROW;
                    last_next      = last_rsec;
                    if (row_hit)
                    begin
                        found_next = 1'b1;
                    end
                    else if (!found_reg)
                    begin
                        rrem_next = rrem_reg - {1'b0, sh_eff};
                    end
                    rsec_next = rsec_reg + NH_W'(1);
                    if (last_rsec)
                    begin
                        // advance the scan row and the pwm time base
                        scan_row_next = (row_inc >= height_eff) ? '0 : row_inc[RW-1:0];
                        pwm_time_next = pwm_time_reg + LW'(1);
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            scan_row_reg  <= '0;
            pwm_time_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            cidx_reg      <= '0;
            sec_reg       <= '0;
            rsec_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            scan_row_reg  <= scan_row_next;
            pwm_time_reg  <= pwm_time_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            cidx_reg      <= cidx_next;
            sec_reg       <= sec_next;
            rsec_reg      <= rsec_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        rrem_reg      <= rrem_next;
        col_reg       <= col_next;
        acc_reg       <= acc_next;
        out_byte_reg  <= out_byte_next;
        byte_kind_reg <= byte_kind_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign byte_kind = byte_kind_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // the frame store is only written on a pixel write or during clearing
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        fs_wr.en |-> (state_reg == S_IDLE || state_reg == S_CLR))
        else $error("frame store written during a row tick");

    // a row-select byte selects at most one row
    a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_kind == lmps_pkg::KIND_ROW) |-> $onehot0(out_byte))
        else $error("row-select byte not one-hot");

    // column bytes never close a row tick
    a_col_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_kind == lmps_pkg::KIND_COLUMN) |-> !last)
        else $error("column byte flagged last");

    // the row being scanned lies inside the display
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ({1'b0, row_reg} < height_eff))
        else $error("scan row outside display");

    // pwm time steps by one when the last byte of a tick is loaded
    a_pwm_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW && out_free && last_rsec)
        |=> (pwm_time_reg == $past(pwm_time_reg) + LW'(1)) && (state_reg == S_IDLE))
        else $error("pwm time did not advance at end of tick");
`endif

endmodule

### hw/rtl/lmps_frame_store.sv
`timescale 1ns / 1ps

module lmps_frame_store
(
    input  logic                             clk,
    input  lmps_pkg::fs_wr_t                 wr,
    input  logic [lmps_pkg::STORE_ADDR_W-1:0] rd_addr,
    output logic [lmps_pkg::LEVEL_W-1:0]      rd_data
);

    logic [lmps_pkg::LEVEL_W-1:0] mem [lmps_pkg::STORE_DEPTH];
    logic [lmps_pkg::LEVEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    // widths the stimulus narrows random numbers to
    localparam int SIDE_W  = lmps_pkg::SIDE_W;
    localparam int LEVEL_W = lmps_pkg::LEVEL_W;
    localparam int CFG_W   = lmps_pkg::CFG_W;

    // timing
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    // a clear sweeps the whole store with no byte to show for it
    localparam int SETTLE_CYCLES  = lmps_pkg::STORE_DEPTH + 64;
    // leave some margin at the end after the last row tick
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    // random part: eight phases of twelve words
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 12;
    localparam int PAUSE_PHASE = 4;
    localparam int HOLD_PHASE  = 6;

    // the one request code the package leaves unnamed
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [lmps_pkg::BYTE_W-1:0] value;
        logic                        kind;
        logic                        last;
    } scan_byte_t;

    // one row of the directed table; relayout writes the four registers first,
    // typed rows carry the column byte and row-select byte of a one by one
    // section layout instead of asking the predictor
    typedef struct packed {
        logic                         relayout;
        logic [lmps_pkg::SIZE_W-1:0]  lw;
        logic [lmps_pkg::SIZE_W-1:0]  lh;
        logic [CFG_W-1:0]             lnw;
        logic [CFG_W-1:0]             lnh;
        logic [1:0]                   req;
        logic [SIDE_W-1:0]            prow;
        logic [SIDE_W-1:0]            pcol;
        logic [LEVEL_W-1:0]           plevel;
        logic                         typed;
        logic [lmps_pkg::BYTE_W-1:0]  want_col;
        logic [lmps_pkg::BYTE_W-1:0]  want_sel;
    } directed_word_t;

    // ports
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [lmps_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]               cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [1:0]                     req_type    = '0;
    logic [SIDE_W-1:0]              pixel_row   = '0;
    logic [SIDE_W-1:0]              pixel_col   = '0;
    logic [LEVEL_W-1:0]             pixel_level = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic [lmps_pkg::BYTE_W-1:0]    out_byte;
    logic                           byte_kind;
    logic                           last;

    // shadow of the block: frame store, scan position, pwm time, raw registers
    logic [LEVEL_W-1:0]           shadow_store [lmps_pkg::STORE_DEPTH];
    logic [SIDE_W-1:0]            shadow_row;
    logic [7:0]                   shadow_time;
    logic [lmps_pkg::SIZE_W-1:0]  lay_w;
    logic [lmps_pkg::SIZE_W-1:0]  lay_h;
    logic [lmps_pkg::COUNT_W-1:0] lay_nw;
    logic [lmps_pkg::COUNT_W-1:0] lay_nh;

    // bytes still owed by the block, oldest first
    scan_byte_t expected_bytes [$];
    scan_byte_t tick_bytes [$];
    int         err_count = 0;

    // pacing, percent of cycles each side spends idle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;

    // directed words, walked once after reset, starting at the reset layout
    directed_word_t directed_words [25] = '{
        // empty store after reset: all columns dark, top row selected
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,   31, 31, 8'hFF, 1, 8'hFF, 8'h80},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   0,  0, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   0,  7, 8'h01, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   1,  3, 8'h80, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   1,  0, 8'h02, 0, 0, 0},
        // pixels below, right of and far outside the 8 x 8 display are dropped
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   8,  0, 8'h55, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   0,  8, 8'hAA, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,  31, 31, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 0, 0, 0},
        // unknown request with every field at its top
        '{0, 0, 0, 0, 0, REQ_UNKNOWN,          31, 31, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   3,  1, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_CLEAR,  31, 31, 8'hFF, 0, 0, 0},
        // cleared store, fourth row selected
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 1, 8'hFF, 8'h10},
        // every register past its range: clamps to 8 x 8 sections, 4 x 4
        '{1, 15, 15, 15, 15, lmps_pkg::REQ_WRITE, 31, 31, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   4,  0, 8'hFF, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   4, 31, 8'h09, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 0, 0, 0},
        // all registers zero: one pixel display, stale row falls back to 0,
        // unused column bits stay high
        '{1, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 1, 8'hFF, 8'h01},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,   0,  0, 8'hFF, 0, 0, 0},
        // single row wraps on every tick
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 1, 8'hFE, 8'h01},
        // count registers keep only three bits: 8 reads as 0, 12 as 4
        '{1, 3, 5, 8, 12, lmps_pkg::REQ_WRITE, 19,  2, 8'hC0, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_WRITE,  19,  3, 8'h00, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,    0,  0, 8'h00, 0, 0, 0},
        '{0, 0, 0, 0, 0, lmps_pkg::REQ_TICK,   31, 31, 8'hFF, 0, 0, 0}
    };

    led_matrix_pwm_row_scanner DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .pixel_level (pixel_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_kind   (byte_kind),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // zero counts as one, anything past the limit counts as the limit
    function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned disp_cols();
        int unsigned v;
        v = clamp_reg(32'(lay_w), lmps_pkg::DEF_SECTION_BITS)
            * clamp_reg(32'(lay_nw), lmps_pkg::DEF_MAX_SECTIONS_WIDE);
        return (v > lmps_pkg::STORE_SIDE) ? lmps_pkg::STORE_SIDE : v;
    endfunction

    function automatic int unsigned disp_rows();
        int unsigned v;
        v = clamp_reg(32'(lay_h), lmps_pkg::DEF_SECTION_BITS)
            * clamp_reg(32'(lay_nh), lmps_pkg::DEF_MAX_SECTIONS_HIGH);
        return (v > lmps_pkg::STORE_SIDE) ? lmps_pkg::STORE_SIDE : v;
    endfunction

    // apply one accepted word to the shadow, return the bytes a tick sends
    function automatic void apply_request(input logic [1:0] req,
                                          input logic [SIDE_W-1:0] prow,
                                          input logic [SIDE_W-1:0] pcol,
                                          input logic [LEVEL_W-1:0] plevel,
                                          ref scan_byte_t produced [$]);
        int unsigned sw, sh, nw, nh, rows, cols, total, r, col, k, s, c;
        logic [LEVEL_W-1:0]          lvl;
        logic [lmps_pkg::BYTE_W-1:0] b;
        sw    = clamp_reg(32'(lay_w), lmps_pkg::DEF_SECTION_BITS);
        sh    = clamp_reg(32'(lay_h), lmps_pkg::DEF_SECTION_BITS);
        nw    = clamp_reg(32'(lay_nw), lmps_pkg::DEF_MAX_SECTIONS_WIDE);
        nh    = clamp_reg(32'(lay_nh), lmps_pkg::DEF_MAX_SECTIONS_HIGH);
        rows  = disp_rows();
        cols  = disp_cols();
        total = nw + nh;
        k     = 0;
        produced.delete();
        case (req)
            lmps_pkg::REQ_WRITE:
            begin
                if (32'(prow) < rows && 32'(pcol) < cols)
                    shadow_store[{prow, pcol}] = plevel;
            end
            lmps_pkg::REQ_CLEAR:
            begin
                foreach (shadow_store[i])
                    shadow_store[i] = '0;
            end
            lmps_pkg::REQ_TICK:
            begin
                r = 32'(shadow_row);
                if (r >= rows)
                    r = 0;
                for (s = 0; s < nw; s++)
                begin
                    b = '1;
                    for (c = 0; c < sw; c++)
                    begin
                        col = s * sw + c;
                        lvl = (col < lmps_pkg::STORE_SIDE)
                              ? shadow_store[{r[SIDE_W-1:0], col[SIDE_W-1:0]}] : '0;
                        if (lvl > shadow_time)
                            b[3'(sw - 1 - c)] = 1'b0;
                    end
                    produced.push_back('{value: b, kind: lmps_pkg::KIND_COLUMN,
                                         last: (k + 1 == total)});
                    k++;
                end
                for (s = 0; s < nh; s++)
                begin
                    b = '0;
                    if (r / sh == s)
                        b[3'(sh - 1 - r % sh)] = 1'b1;
                    produced.push_back('{value: b, kind: lmps_pkg::KIND_ROW,
                                         last: (k + 1 == total)});
                    k++;
                end
                r++;
                if (r >= rows)
                    r = 0;
                shadow_row  = r[SIDE_W-1:0];
                shadow_time = shadow_time + 8'd1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // offer one word, return at the edge where it is taken
    task automatic send_word(input logic [1:0] req, input logic [SIDE_W-1:0] prow,
                             input logic [SIDE_W-1:0] pcol, input logic [LEVEL_W-1:0] plevel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_row   <= prow;
        pixel_col   <= pcol;
        pixel_level <= plevel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] req, input logic [SIDE_W-1:0] prow,
                         input logic [SIDE_W-1:0] pcol, input logic [LEVEL_W-1:0] plevel);
        send_word(req, prow, pcol, plevel);
        apply_request(req, prow, pcol, plevel, tick_bytes);
        foreach (tick_bytes[i])
            expected_bytes.push_back(tick_bytes[i]);
    endtask

    // sender goes quiet until every owed byte has come out
    task automatic drain_bytes();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // drained, plus room for a clear that sends nothing
    task automatic wait_idle();
        drain_bytes();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [lmps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            lmps_pkg::REG_SECTION_WIDTH:  lay_w  = val[lmps_pkg::SIZE_W-1:0];
            lmps_pkg::REG_SECTION_HEIGHT: lay_h  = val[lmps_pkg::SIZE_W-1:0];
            lmps_pkg::REG_SECTIONS_WIDE:  lay_nw = val[lmps_pkg::COUNT_W-1:0];
            lmps_pkg::REG_SECTIONS_HIGH:  lay_nh = val[lmps_pkg::COUNT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_layout(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] nw, input logic [CFG_W-1:0] nh);
        wait_idle();
        write_reg(lmps_pkg::REG_SECTION_WIDTH, w);
        write_reg(lmps_pkg::REG_SECTION_HEIGHT, h);
        write_reg(lmps_pkg::REG_SECTIONS_WIDE, nw);
        write_reg(lmps_pkg::REG_SECTIONS_HIGH, nh);
        cfg_we <= 1'b0;
    endtask

    // receiver: random stalls, or a long hold counted down here
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // every byte taken is matched against the oldest one owed
    always @(posedge clk)
    begin : byte_check
        scan_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %02h byte_kind %0b last %0b",
                       out_byte, byte_kind, last);
                err_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $error("out_byte: expected %02h, got %02h", want.value, out_byte);
                    err_count++;
                end
                if (byte_kind !== want.kind)
                begin
                    $error("byte_kind: expected %0b, got %0b", want.kind, byte_kind);
                    err_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        directed_word_t     d;
        logic [1:0]         req;
        logic [SIDE_W-1:0]  prow;
        logic [SIDE_W-1:0]  pcol;
        logic [LEVEL_W-1:0] plevel;
        int                 pick;

        // shadow matches the block after reset
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        shadow_row  = '0;
        shadow_time = '0;
        lay_w       = lmps_pkg::RST_SECTION_WIDTH;
        lay_h       = lmps_pkg::RST_SECTION_HEIGHT;
        lay_nw      = lmps_pkg::RST_SECTIONS_WIDE;
        lay_nh      = lmps_pkg::RST_SECTIONS_HIGH;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // the block sweeps its store once after reset
        wait_idle();

        // directed words, sender mostly busy, receiver mostly stalled
        send_idle_pct  = 13;
        recv_stall_pct = 65;
        foreach (directed_words[i])
        begin
            d = directed_words[i];
            if (d.relayout)
                set_layout(d.lw, d.lh, d.lnw, d.lnh);
            if (d.typed)
            begin
                send_word(d.req, d.prow, d.pcol, d.plevel);
                apply_request(d.req, d.prow, d.pcol, d.plevel, tick_bytes);
                expected_bytes.push_back('{value: d.want_col, kind: lmps_pkg::KIND_COLUMN,
                                           last: 1'b0});
                expected_bytes.push_back('{value: d.want_sel, kind: lmps_pkg::KIND_ROW,
                                           last: 1'b1});
            end
            else
                issue(d.req, d.prow, d.pcol, d.plevel);
        end

        // random phases: extremes of the layout first, then random layouts
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:       set_layout(4'd8, 4'd8, 4'd4, 4'd4);
                1:       set_layout(4'd1, 4'd1, 4'd1, 4'd1);
                2:       set_layout(4'd0, 4'd0, 4'd0, 4'd0);
                3:       set_layout(4'd15, 4'd15, 4'd15, 4'd15);
                default: set_layout(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                                    CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)));
            endcase

            // swap who idles from phase 3 on, no idling at all from the hold phase on
            if (phase < 3)
            begin
                send_idle_pct  = 13;
                recv_stall_pct = 65;
            end
            else if (phase < HOLD_PHASE)
            begin
                send_idle_pct  = 65;
                recv_stall_pct = 13;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // receiver goes deaf for a while, ticks keep coming and back up
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == PAUSE_PHASE && n == PHASE_WORDS / 2)
                    drain_bytes();
                pick   = $urandom_range(99);
                prow   = SIDE_W'($urandom_range(31));
                pcol   = SIDE_W'($urandom_range(31));
                plevel = LEVEL_W'($urandom_range(255));
                if (pick < 50 || (phase == HOLD_PHASE && n < 8))
                    req = lmps_pkg::REQ_TICK;
                else if (pick < 88)
                begin
                    req = lmps_pkg::REQ_WRITE;
                    // mostly pixels on the display, sometimes levels near the pwm edge
                    if ($urandom_range(4) != 0)
                    begin
                        prow = SIDE_W'($urandom_range(disp_rows() - 1));
                        pcol = SIDE_W'($urandom_range(disp_cols() - 1));
                    end
                    if ($urandom_range(3) == 0)
                        plevel = shadow_time + LEVEL_W'($urandom_range(1));
                end
                else if (pick < 95)
                    req = REQ_UNKNOWN;
                else
                    req = lmps_pkg::REQ_CLEAR;
                issue(req, prow, pcol, plevel);
            end
        end

        // 8 x 4 display with random levels, a few ticks across it
        set_layout(4'd8, 4'd2, 4'd1, 4'd2);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 8; c++)
                issue(lmps_pkg::REQ_WRITE, SIDE_W'(r), SIDE_W'(c),
                      LEVEL_W'($urandom_range(255)));
        repeat (8)
            issue(lmps_pkg::REQ_TICK, SIDE_W'($urandom_range(31)),
                  SIDE_W'($urandom_range(31)), LEVEL_W'($urandom_range(255)));

        drain_bytes();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (err_count == 0 && expected_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
